### sv/bpet_pkg.sv
// ----------------------------------------------------------------------------
// bpet_pkg
// Shared constants and types for the button press event timer.
// ----------------------------------------------------------------------------
package bpet_pkg;

    // Number of buttons timed; storage and scan length follow from it
    localparam int BUTTONS     = 8;
    localparam int IDX_W       = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

    localparam int BTN_W       = 3;    // button field width
    localparam int CODE_W      = 3;    // event code width
    localparam int TICK_W      = 16;   // threshold register width
    localparam int CNT_W       = 18;   // per-button counter width
    localparam int EV_N        = 5;    // number of event kinds
    localparam int MAX_RESULTS = 40;   // result cap per tick
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);
    localparam int CFG_IDX_W   = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Input kinds (s_tuser)
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_LEVEL = 1'b1;

    // Event codes; also bit positions in fired flags and enables
    localparam logic [CODE_W-1:0] EV_SHORT  = 3'd0;
    localparam logic [CODE_W-1:0] EV_NORMAL = 3'd1;
    localparam logic [CODE_W-1:0] EV_LONG   = 3'd2;
    localparam logic [CODE_W-1:0] EV_REPEAT = 3'd3;
    localparam logic [CODE_W-1:0] EV_STUCK  = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHORT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STUCK  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd5;

    typedef struct packed {
        logic [TICK_W-1:0] short_ticks;
        logic [TICK_W-1:0] normal_ticks;
        logic [TICK_W-1:0] long_ticks;
        logic [TICK_W-1:0] repeat_ticks;
        logic [TICK_W-1:0] stuck_ticks;
        logic [EV_N-1:0]   event_enable;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic             level_wr;    // apply a level item
        logic             tick_start;  // new tick: clear result count
        logic             eval;        // evaluate button idx
        logic             emit_step;   // move one event into the hold stage
        logic             flush_step;  // send held event as the final one
        logic [IDX_W-1:0] idx;         // button being scanned
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic mask_empty;   // no events left for this button
        logic hold_valid;   // an event waits in the hold stage
        logic out_free;     // output register can load this cycle
    } dp_stat_t;

endpackage

### sv/bpet_cfg.sv
// ----------------------------------------------------------------------------
// bpet_cfg
// Configuration register file: thresholds and event enables.
// ----------------------------------------------------------------------------
module bpet_cfg
    import bpet_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [TICK_W-1:0]    cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_ticks  <= 16'd5;
            cfg_reg.normal_ticks <= 16'd50;
            cfg_reg.long_ticks   <= 16'd200;
            cfg_reg.repeat_ticks <= 16'd20;
            cfg_reg.stuck_ticks  <= 16'd3000;
            cfg_reg.event_enable <= '1;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_SHORT:  cfg_reg.short_ticks  <= cfg_wdata;
                REG_NORMAL: cfg_reg.normal_ticks <= cfg_wdata;
                REG_LONG:   cfg_reg.long_ticks   <= cfg_wdata;
                REG_REPEAT: cfg_reg.repeat_ticks <= cfg_wdata;
                REG_STUCK:  cfg_reg.stuck_ticks  <= cfg_wdata;
                REG_ENABLE: cfg_reg.event_enable <= cfg_wdata[EV_N-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/bpet_ctrl.sv
// ----------------------------------------------------------------------------
// bpet_ctrl
// Sequencer: accepts items, walks the buttons on a tick, paces the emit path.
// ----------------------------------------------------------------------------
module bpet_ctrl
    import bpet_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_cmd,
    output logic       s_tready,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             last_btn;

    assign last_btn = (idx_reg == IDX_W'(BUTTONS - 1));
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmd            = '0;
        cmd.idx        = idx_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_cmd == CMD_LEVEL) begin
                        cmd.level_wr = 1'b1;
                    end else begin
                        cmd.tick_start = 1'b1;
                        idx_next       = '0;
                        state_next     = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (stat.mask_empty) begin
                    if (last_btn) begin
                        state_next = S_FLUSH;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_EVAL;
                    end
                end else if (!stat.hold_valid || stat.out_free) begin
                    cmd.emit_step = 1'b1;
                end
            end
            S_FLUSH: begin
                if (!stat.hold_valid) begin
                    state_next = S_IDLE;
                end else if (stat.out_free) begin
                    cmd.flush_step = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

### sv/bpet_dp.sv
// ----------------------------------------------------------------------------
// bpet_dp
// Datapath: per-button state, event evaluation, hold stage and output register.
// ----------------------------------------------------------------------------
module bpet_dp
    import bpet_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  ctrl_cmd_t         cmd,
    output dp_stat_t          stat,
    input  logic [BTN_W-1:0]  s_button,
    input  logic              s_pressed,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BTN_W-1:0]  m_button_id,
    output logic [CODE_W-1:0] m_event_code,
    output logic              m_tlast
);

    // per-button state
    logic             level_reg [BUTTONS];
    logic [CNT_W-1:0] held_reg  [BUTTONS];
    logic [CNT_W-1:0] rep_reg   [BUTTONS];
    logic [EV_N-1:0]  fired_reg [BUTTONS];

    logic [RES_W-1:0] res_cnt_reg, res_cnt_next;
    logic [EV_N-1:0]  mask_reg;

    logic              hold_valid_reg;
    logic [BTN_W-1:0]  hold_id_reg;
    logic [CODE_W-1:0] hold_code_reg;

    logic              out_valid_reg;
    logic [BTN_W-1:0]  out_id_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic              out_last_reg;

    // level item decode
    logic             lvl_in_range;
    logic [IDX_W-1:0] lvl_idx;
    logic             lvl_change;

    assign lvl_in_range = (32'(s_button) < BUTTONS);
    assign lvl_idx      = IDX_W'(s_button);
    assign lvl_change   = cmd.level_wr && lvl_in_range && (level_reg[lvl_idx] != s_pressed);

    // evaluation of the scanned button
    logic             cur_lvl;
    logic [CNT_W-1:0] held_inc, rep_inc, rep_limit, held_next, rep_next;
    logic [EV_N-1:0]  fired_cur, fired_next, ev_mask;
    logic             active;
    logic             f_short, f_normal, f_long, f_repeat, f_stuck;
    logic [RES_W-1:0] n1, n2, n3, n4;
    logic [TICK_W:0]  first_rep;

    assign cur_lvl   = level_reg[cmd.idx];
    assign fired_cur = fired_reg[cmd.idx];
    assign held_inc  = (cur_lvl && held_reg[cmd.idx] != CNT_MAX) ?
                       held_reg[cmd.idx] + 1'b1 : held_reg[cmd.idx];
    assign rep_inc   = (cur_lvl && rep_reg[cmd.idx] != CNT_MAX) ?
                       rep_reg[cmd.idx] + 1'b1 : rep_reg[cmd.idx];
    assign active    = cur_lvl && !fired_cur[EV_STUCK];
    assign first_rep = {1'b0, cfg.normal_ticks} + {1'b0, cfg.repeat_ticks};
    assign rep_limit = fired_cur[EV_REPEAT] ? CNT_W'(cfg.repeat_ticks) : CNT_W'(first_rep);

    // events in order, each only while the per-tick cap leaves room
    always_comb begin
        f_short  = active && cfg.event_enable[EV_SHORT] && !fired_cur[EV_SHORT] &&
                   (held_inc >= CNT_W'(cfg.short_ticks)) &&
                   (res_cnt_reg < RES_W'(MAX_RESULTS));
        n1       = res_cnt_reg + RES_W'(f_short);
        f_normal = active && cfg.event_enable[EV_NORMAL] && !fired_cur[EV_NORMAL] &&
                   (held_inc >= CNT_W'(cfg.normal_ticks)) && (n1 < RES_W'(MAX_RESULTS));
        n2       = n1 + RES_W'(f_normal);
        f_long   = active && cfg.event_enable[EV_LONG] && !fired_cur[EV_LONG] &&
                   (held_inc >= CNT_W'(cfg.long_ticks)) && (n2 < RES_W'(MAX_RESULTS));
        n3       = n2 + RES_W'(f_long);
        f_repeat = active && cfg.event_enable[EV_REPEAT] &&
                   (rep_inc >= rep_limit) && (n3 < RES_W'(MAX_RESULTS));
        n4       = n3 + RES_W'(f_repeat);
        f_stuck  = active && cfg.event_enable[EV_STUCK] &&
                   (held_inc >= CNT_W'(cfg.stuck_ticks)) && (n4 < RES_W'(MAX_RESULTS));
        res_cnt_next = n4 + RES_W'(f_stuck);
    end

    assign ev_mask    = {f_stuck, f_repeat, f_long, f_normal, f_short};
    assign fired_next = fired_cur | ev_mask;
    assign held_next  = held_inc;
    assign rep_next   = f_repeat ? '0 : rep_inc;

    // lowest pending event of this button
    logic [CODE_W-1:0] pick_code;
    logic [EV_N-1:0]   pick_clr;

    always_comb begin
        pick_code = EV_SHORT;
        pick_clr  = '0;
        for (int k = EV_N - 1; k >= 0; k--) begin
            if (mask_reg[k]) begin
                pick_code = CODE_W'(k);
                pick_clr  = EV_N'(1) << k;
            end
        end
    end

    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    assign stat.mask_empty = (mask_reg == '0);
    assign stat.hold_valid = hold_valid_reg;
    assign stat.out_free   = out_free;

    // state arrays
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BUTTONS; i++) begin
                level_reg[i] <= 1'b0;
                held_reg[i]  <= '0;
                rep_reg[i]   <= '0;
                fired_reg[i] <= '0;
            end
        end else begin
            if (lvl_change) begin
                level_reg[lvl_idx] <= s_pressed;
                held_reg[lvl_idx]  <= '0;
                rep_reg[lvl_idx]   <= '0;
                fired_reg[lvl_idx] <= '0;
            end
            if (cmd.eval) begin
                held_reg[cmd.idx]  <= held_next;
                rep_reg[cmd.idx]   <= rep_next;
                fired_reg[cmd.idx] <= fired_next;
            end
        end
    end

    // scan bookkeeping and hold stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_cnt_reg    <= '0;
            mask_reg       <= '0;
            hold_valid_reg <= 1'b0;
        end else begin
            if (cmd.tick_start) begin
                res_cnt_reg <= '0;
            end
            if (cmd.eval) begin
                res_cnt_reg <= res_cnt_next;
                mask_reg    <= ev_mask;
            end
            if (cmd.emit_step) begin
                mask_reg       <= mask_reg & ~pick_clr;
                hold_valid_reg <= 1'b1;
            end
            if (cmd.flush_step) begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_step) begin
            hold_id_reg   <= BTN_W'(cmd.idx);
            hold_code_reg <= pick_code;
        end
    end

    // output register
    logic out_load;
    assign out_load = (cmd.emit_step && hold_valid_reg) || cmd.flush_step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_id_reg   <= hold_id_reg;
            out_code_reg <= hold_code_reg;
            out_last_reg <= cmd.flush_step;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign m_button_id  = out_id_reg;
    assign m_event_code = out_code_reg;
    assign m_tlast      = out_last_reg;

endmodule

### sv/button_press_event_timer_top.sv
// ----------------------------------------------------------------------------
// button_press_event_timer_top
// Long-press, auto-repeat and stuck-button event timer for up to eight buttons.
// ----------------------------------------------------------------------------
// Usage notes
//  - Input channel (s_*): one item is either a level update (s_tuser = 1) for
//    one button, or a time tick (s_tuser = 0). s_tready is high only while the
//    block is idle, so one item is worked on at a time.
//  - A level update is taken without leaving idle and never produces an event.
//  - A tick walks the buttons in index order, with an evaluate step and then
//    a look for pending events per button, moving out one event at a time,
//    and ends with a closing flush step; the block is busy until then and
//    takes the next item once it is back in idle.
//  - Result channel (m_*): one item per event. An event waits in a hold stage
//    until the next is found or the scan closes, so the final one can carry
//    m_tlast; an item reaches the output register only from the hold stage.
//  - A stalled receiver (m_tready low) holds the output register and the hold
//    stage; the scan pauses until the output register frees. Nothing is lost.
//  - A tick that raises no event gives no result item.
//  - Configuration writes (cfg_we) take effect at once and belong in idle
//    periods. Reset restores the default thresholds, all enables set, all
//    buttons released and every counter and fired flag cleared.
// ----------------------------------------------------------------------------
module button_press_event_timer_top
    import bpet_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [2:0] button, [3] pressed, [7:4] zero
    input  logic                 s_tuser,   // [0] cmd: 0 tick, 1 level update

    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [2:0] button_id, [5:3] event_code, [7:6] zero
    output logic                 m_tlast,   // final event of this tick

    // configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [TICK_W-1:0]    cfg_wdata
);

    cfg_t              cfg;
    ctrl_cmd_t         cmd;
    dp_stat_t          stat;
    logic [BTN_W-1:0]  out_id;
    logic [CODE_W-1:0] out_code;

    bpet_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bpet_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_cmd    (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bpet_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .cmd          (cmd),
        .stat         (stat),
        .s_button     (s_tdata[2:0]),
        .s_pressed    (s_tdata[3]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_button_id  (out_id),
        .m_event_code (out_code),
        .m_tlast      (m_tlast)
    );

    // pack result fields, padded to a whole byte
    assign m_tdata = {2'b00, out_code, out_id};

endmodule

### dv/button_press_event_timer_top_test.sv
// ----------------------------------------------------------------------------
// button_press_event_timer_top_test
// Self-checking bench for the button press event timer. Level and tick items
// go into the input stream in random bursts; a scoreboard predicts every
// event a tick raises and checks the result stream item by item, with the
// receiver stalling on its own pattern and once holding off for a long spell.
// ----------------------------------------------------------------------------
module button_press_event_timer_top_test;
    import bpet_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // level values carried in the pressed bit
    localparam logic LVL_PRESSED  = 1'b1;
    localparam logic LVL_RELEASED = 1'b0;

    // register indexes that decode to nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

    localparam logic [TICK_W-1:0] EN_ALL   = 16'h001F;
    localparam logic [TICK_W-1:0] TICK_TOP = 16'hFFFF;

    // worst tick: full scan, every event moved out, closing step, a little slack
    localparam int SETTLE_CYCLES = 2 * BUTTONS + 1 + MAX_RESULTS + 8;
    localparam int HOLD_OFF      = 300;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    typedef struct {
        logic [BTN_W-1:0]  button_id;
        logic [CODE_W-1:0] event_code;
        logic              is_last;
    } event_item_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'h00;   // [2:0] button, [3] pressed, [7:4] zero
    logic                 s_tuser   = 1'b0;    // [0] cmd: 0 tick, 1 level update
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;             // [2:0] button_id, [5:3] event_code
    logic                 m_tlast;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [TICK_W-1:0]    cfg_wdata = '0;

    button_press_event_timer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Scoreboard copy of the block state and its registers
    // ------------------------------------------------------------------------
    logic [TICK_W-1:0] thr_short, thr_normal, thr_long, thr_repeat, thr_stuck;
    logic [EV_N-1:0]   ev_enable;
    logic              btn_down   [BUTTONS];
    logic [CNT_W-1:0]  press_age  [BUTTONS];
    logic [CNT_W-1:0]  repeat_age [BUTTONS];
    logic [EV_N-1:0]   fired      [BUTTONS];

    event_item_t pending_events[$];   // events owed by the block, oldest first
    event_item_t oldest;

    // sender pacing
    bit gaps_on    = 1'b0;
    int burst_left = 0;

    // receiver control
    rx_mode_t rx_mode   = RX_ALWAYS;
    logic [7:0] rx_pat  = 8'b1011_0110;
    bit       hold_req  = 1'b0;
    int       hold_left = 0;

    // bookkeeping
    int fail_count   = 0;
    int items_sent   = 0;
    int ticks_sent   = 0;
    int events_seen  = 0;
    int reg_writes   = 0;
    int max_per_tick = 0;

    // ------------------------------------------------------------------------
    // Prediction: one tick item. Age every pressed button, then scan in index
    // order for due events; the final event of the tick carries last.
    // ------------------------------------------------------------------------
    task automatic predict_tick_events();
        event_item_t evs[$];
        event_item_t ev;
        int unsigned rpt_limit;
        for (int b = 0; b < BUTTONS; b++) begin
            if (btn_down[b]) begin
                if (press_age[b] != CNT_MAX) press_age[b]++;
                if (repeat_age[b] != CNT_MAX) repeat_age[b]++;
            end
        end
        for (int b = 0; b < BUTTONS; b++) begin
            // stuck buttons stay quiet until the next level change
            if (btn_down[b] && !fired[b][EV_STUCK]) begin
                ev.button_id = b[BTN_W-1:0];
                ev.is_last   = 1'b0;
                if (ev_enable[EV_SHORT] && !fired[b][EV_SHORT] &&
                    press_age[b] >= thr_short && evs.size() < MAX_RESULTS) begin
                    ev.event_code = EV_SHORT;
                    evs.push_back(ev);
                    fired[b][EV_SHORT] = 1'b1;
                end
                if (ev_enable[EV_NORMAL] && !fired[b][EV_NORMAL] &&
                    press_age[b] >= thr_normal && evs.size() < MAX_RESULTS) begin
                    ev.event_code = EV_NORMAL;
                    evs.push_back(ev);
                    fired[b][EV_NORMAL] = 1'b1;
                end
                if (ev_enable[EV_LONG] && !fired[b][EV_LONG] &&
                    press_age[b] >= thr_long && evs.size() < MAX_RESULTS) begin
                    ev.event_code = EV_LONG;
                    evs.push_back(ev);
                    fired[b][EV_LONG] = 1'b1;
                end
                if (ev_enable[EV_REPEAT]) begin
                    // first repeat waits out the normal delay as well
                    rpt_limit = fired[b][EV_REPEAT] ? 32'(thr_repeat)
                                                    : 32'(thr_normal) + 32'(thr_repeat);
                    if (32'(repeat_age[b]) >= rpt_limit && evs.size() < MAX_RESULTS) begin
                        ev.event_code = EV_REPEAT;
                        evs.push_back(ev);
                        fired[b][EV_REPEAT] = 1'b1;
                        repeat_age[b] = '0;
                    end
                end
                if (ev_enable[EV_STUCK] && press_age[b] >= thr_stuck &&
                    evs.size() < MAX_RESULTS) begin
                    ev.event_code = EV_STUCK;
                    evs.push_back(ev);
                    fired[b][EV_STUCK] = 1'b1;
                end
            end
        end
        if (evs.size() > 0) evs[evs.size()-1].is_last = 1'b1;
        if (evs.size() > max_per_tick) max_per_tick = evs.size();
        foreach (evs[i]) pending_events.push_back(evs[i]);
    endtask

    // ------------------------------------------------------------------------
    // Send one item; called just after a rising edge. Acceptance is judged at
    // the falling edge, where both handshake signals are settled. Valid stays
    // high into the next item unless a gap is due.
    // ------------------------------------------------------------------------
    task automatic send_item(logic cmd, logic [BTN_W-1:0] btn, logic prs);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0000, prs, btn};
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        if (cmd == CMD_LEVEL) begin
            // a repeated level changes nothing
            if (btn_down[btn] != prs) begin
                btn_down[btn]   = prs;
                press_age[btn]  = '0;
                repeat_age[btn] = '0;
                fired[btn]      = '0;
            end
        end else begin
            predict_tick_events();
            ticks_sent++;
        end
        @(posedge aclk);
        items_sent++;
        if (gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap = $urandom_range(1, 6);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
                burst_left = $urandom_range(0, 7);
            end
        end
    endtask

    // drop valid, let every owed event arrive, then let a quiet tick finish
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register write; only ever called with the block idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_SHORT:  thr_short  = val;
            REG_NORMAL: thr_normal = val;
            REG_LONG:   thr_long   = val;
            REG_REPEAT: thr_repeat = val;
            REG_STUCK:  thr_stuck  = val;
            REG_ENABLE: ev_enable  = val[EV_N-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic program_timer(logic [TICK_W-1:0] sh, logic [TICK_W-1:0] nm,
                                 logic [TICK_W-1:0] lg, logic [TICK_W-1:0] rp,
                                 logic [TICK_W-1:0] st, logic [TICK_W-1:0] en);
        write_reg(REG_SHORT,  sh);
        write_reg(REG_NORMAL, nm);
        write_reg(REG_LONG,   lg);
        write_reg(REG_REPEAT, rp);
        write_reg(REG_STUCK,  st);
        write_reg(REG_ENABLE, en);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: own stall pattern, overridden by a long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        rx_pat <= {rx_pat[6:0], rx_pat[7]};
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_OFF;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  m_tready <= 1'b1;
                RX_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
                default:    m_tready <= rx_pat[0];
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: sampled at the falling edge, ahead of the accepting edge
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                $error("unexpected result item: button_id %0d event_code %0d last %0d",
                       m_tdata[2:0], m_tdata[5:3], m_tlast);
                fail_count++;
            end else begin
                oldest = pending_events.pop_front();
                events_seen++;
                if (m_tdata[2:0] !== oldest.button_id) begin
                    $error("button_id: expected %0d, got %0d", oldest.button_id, m_tdata[2:0]);
                    fail_count++;
                end
                if (m_tdata[5:3] !== oldest.event_code) begin
                    $error("event_code: expected %0d, got %0d",
                           oldest.event_code, m_tdata[5:3]);
                    fail_count++;
                end
                if (m_tlast !== oldest.is_last) begin
                    $error("last: expected %0d, got %0d", oldest.is_last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // reset thresholds: short click after five ticks, nothing else in reach
    task automatic test_reset_defaults();
        send_item(CMD_LEVEL, 3'd2, LVL_PRESSED);
        repeat (5) send_item(CMD_TICK, 3'd0, 1'b0);
        send_item(CMD_LEVEL, 3'd2, LVL_RELEASED);
        wait_drained();
    endtask

    // every event code on two buttons, zero short threshold, repeated level,
    // stuck silencing and writes to undecoded register indexes
    task automatic test_event_ladder();
        write_reg(REG_SPARE6, TICK_TOP);
        write_reg(REG_SPARE7, 16'h0001);
        program_timer(16'd0, 16'd2, 16'd3, 16'd1, 16'd6, EN_ALL);
        send_item(CMD_LEVEL, 3'd0, LVL_PRESSED);
        send_item(CMD_LEVEL, 3'd7, LVL_PRESSED);
        send_item(CMD_LEVEL, 3'd0, LVL_PRESSED);   // same level again
        repeat (7) send_item(CMD_TICK, 3'd7, 1'b1);
        send_item(CMD_LEVEL, 3'd7, LVL_RELEASED);
        send_item(CMD_TICK, 3'd5, 1'b0);           // button 0 stuck: silent
        send_item(CMD_LEVEL, 3'd0, LVL_RELEASED);
        wait_drained();
    endtask

    // top thresholds keep a pressed button quiet; so do cleared enables,
    // with the upper data bits of the enable write set
    task automatic test_extreme_thresholds();
        program_timer(TICK_TOP, TICK_TOP, TICK_TOP, TICK_TOP, TICK_TOP, EN_ALL);
        send_item(CMD_LEVEL, 3'd5, LVL_PRESSED);
        repeat (2) send_item(CMD_TICK, 3'd0, 1'b0);
        wait_drained();
        program_timer(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFE0);
        repeat (2) send_item(CMD_TICK, 3'd0, 1'b0);
        send_item(CMD_LEVEL, 3'd5, LVL_RELEASED);
        wait_drained();
    endtask

    // all eight buttons fire all five events on one tick while the receiver
    // holds off; the block fills and the further ticks back up at the input
    task automatic test_backpressure();
        program_timer(16'd0, 16'd0, 16'd0, 16'd0, 16'd1, EN_ALL);
        rx_mode = RX_ALWAYS;
        gaps_on = 1'b0;
        for (int b = 0; b < BUTTONS; b++) send_item(CMD_LEVEL, b[BTN_W-1:0], LVL_PRESSED);
        hold_req = 1'b1;
        repeat (6) send_item(CMD_TICK, 3'd0, 1'b0);
        for (int b = 0; b < BUTTONS; b++) send_item(CMD_LEVEL, b[BTN_W-1:0], LVL_RELEASED);
        wait_drained();
    endtask

    // mostly press / tick run / release sequences with random content,
    // the rest loose items of any kind
    task automatic test_random_traffic(int phase, int n_items);
        int sent;
        int run;
        logic [BTN_W-1:0] b;
        sent = 0;
        case (phase)
            0: begin
                program_timer(TICK_W'($urandom_range(0, 4)), TICK_W'($urandom_range(0, 10)),
                              TICK_W'($urandom_range(0, 20)), TICK_W'($urandom_range(0, 5)),
                              TICK_W'($urandom_range(10, 60)), EN_ALL);
                rx_mode = RX_ALWAYS;
                gaps_on = 1'b0;   // a stretch with no idling on either side
            end
            1: begin
                program_timer(TICK_W'($urandom_range(0, 3)), TICK_W'($urandom_range(0, 6)),
                              TICK_W'($urandom_range(0, 12)), TICK_W'($urandom_range(0, 3)),
                              TICK_W'($urandom_range(4, 30)), EN_ALL);
                rx_mode = RX_RANDOM;
                gaps_on = 1'b1;
            end
            2: begin
                program_timer(TICK_W'($urandom_range(0, 4)), TICK_W'($urandom_range(0, 8)),
                              TICK_W'($urandom_range(0, 16)), TICK_W'($urandom_range(0, 4)),
                              TICK_W'($urandom_range(6, 40)), TICK_W'($urandom_range(0, 31)));
                rx_mode = RX_PATTERN;
                gaps_on = 1'b1;
            end
            default: begin
                // mixed extremes: long and stuck out of reach
                program_timer(16'd0, TICK_W'($urandom_range(0, 5)), TICK_TOP,
                              TICK_W'($urandom_range(0, 2)), TICK_TOP,
                              TICK_W'($urandom_range(0, 31)));
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                gaps_on = 1'($urandom_range(0, 1));
            end
        endcase
        burst_left = $urandom_range(0, 7);
        while (sent < n_items) begin
            if ($urandom_range(0, 3) != 0) begin
                b   = BTN_W'($urandom_range(0, BUTTONS - 1));
                run = $urandom_range(1, 10);
                send_item(CMD_LEVEL, b, LVL_PRESSED);
                // ignored fields of a tick still toggle
                repeat (run) send_item(CMD_TICK, BTN_W'($urandom_range(0, 7)),
                                       1'($urandom_range(0, 1)));
                sent += run + 1;
                if ($urandom_range(0, 2) != 0) begin
                    send_item(CMD_LEVEL, b, LVL_RELEASED);
                    sent++;
                end
            end else begin
                send_item(1'($urandom_range(0, 1)), BTN_W'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)));
                sent++;
            end
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        thr_short  = 16'd5;
        thr_normal = 16'd50;
        thr_long   = 16'd200;
        thr_repeat = 16'd20;
        thr_stuck  = 16'd3000;
        ev_enable  = 5'h1F;
        for (int b = 0; b < BUTTONS; b++) begin
            btn_down[b]   = 1'b0;
            press_age[b]  = '0;
            repeat_age[b] = '0;
            fired[b]      = '0;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_event_ladder();
        test_extreme_thresholds();
        test_backpressure();
        for (int p = 0; p < 4; p++) test_random_traffic(p, 44);

        wait_drained();
        $display("run covered %0d items (%0d ticks), %0d events checked, largest tick %0d",
                 items_sent, ticks_sent, events_seen, max_per_tick);
        $display("%0d register writes incl. extremes and undecoded indexes, one long hold-off",
                 reg_writes);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog: far beyond the slowest correct run
    initial begin
        #1000000;
        $display("status: fail");
        $finish;
    end

endmodule
